// ===== hw/rtl/positional_list_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared concurrent assertion helpers for the positional list engine.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional list engine package
// Sizes, request and status codes, and controller types.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 16;
  localparam int REQ_W    = 3;
  localparam int ENTRY_W  = 6;
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_POS   = 3'd4;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } ple_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// Positional list engine controller
// Sequences capture, update and result hand-off for one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl
  import ple_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output ple_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.execute = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
    out_valid_d   = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    out_valid_o = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ple_datapath.sv =====
// ----------------------------------------------------------------------------
// Positional list engine datapath
// Shift-cell entry array, request decode and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_datapath
  import ple_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ple_cmd_t            cmd_i,
  input  wire logic [REQ_W-1:0]    req_type_i,
  input  wire logic [DATA_W-1:0]   item_value_i,
  input  wire logic [POS_W-1:0]    position_i,
  output logic [1:0]               status_o,
  output logic [ENTRY_W-1:0]       entry_count_o,
  output logic [DATA_W-1:0]        front_value_o,
  output logic                     front_valid_o
);

  logic [REQ_W-1:0]  kind_q;
  logic [DATA_W-1:0] value_q;
  logic [POS_W-1:0]  pos_q;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] cell_q [CAPACITY];
  logic [DATA_W-1:0] cell_d [CAPACITY];

  status_e           status_d;
  logic              do_ins, do_del, full;
  logic [CNT_W-1:0]  idx;
  logic [CMP_W-1:0]  posx, cntx, posm1;
  logic [DATA_W-1:0] front_d;

  logic [1:0]         res_status_q;
  logic [ENTRY_W-1:0] res_count_q;
  logic [DATA_W-1:0]  res_front_q;
  logic               res_valid_q;

  // Decode the request into a target index and a status.
  always_comb begin
    status_d = STAT_OK;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    idx      = '0;
    posx     = CMP_W'(pos_q);
    cntx     = CMP_W'(count_q);
    posm1    = posx - CMP_W'(1);
    full     = (count_q == CNT_W'(CAPACITY));
    unique case (kind_q)
      REQ_INS_FRONT: begin
        if (full) status_d = STAT_FULL;
        else do_ins = 1'b1;
      end
      REQ_INS_BACK: begin
        if (full) status_d = STAT_FULL;
        else begin
          do_ins = 1'b1;
          idx    = count_q;
        end
      end
      REQ_INS_POS: begin
        if (full) status_d = STAT_FULL;
        else begin
          do_ins = 1'b1;
          if (posx <= CMP_W'(1)) idx = '0;
          else if (posm1 > cntx) idx = count_q;
          else idx = CNT_W'(posm1);
        end
      end
      REQ_DEL_FRONT: begin
        if (count_q == '0) status_d = STAT_EMPTY;
        else do_del = 1'b1;
      end
      REQ_DEL_POS: begin
        if (count_q == '0) status_d = STAT_EMPTY;
        else if (pos_q == '0 || posx > cntx) status_d = STAT_RANGE;
        else begin
          do_del = 1'b1;
          idx    = CNT_W'(posm1);
        end
      end
      default: status_d = STAT_OK;
    endcase

    if (do_ins) count_d = count_q + CNT_W'(1);
    else if (do_del) count_d = count_q - CNT_W'(1);
    else count_d = count_q;

    if (do_ins && idx == '0) front_d = value_q;
    else if (do_del && idx == '0) front_d = cell_q[1];
    else front_d = cell_q[0];
  end

  // Each cell keeps its own value, takes the new item, or takes its left or right neighbor.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_comb begin
      cell_d[g] = cell_q[g];
      if (do_ins) begin
        if (CNT_W'(g) == idx) begin
          cell_d[g] = value_q;
        end else if (CNT_W'(g) > idx) begin
          if (g > 0) cell_d[g] = cell_q[(g > 0) ? g - 1 : 0];
        end
      end else if (do_del) begin
        if (CNT_W'(g) >= idx && g < CAPACITY - 1) begin
          cell_d[g] = cell_q[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.execute) begin
        cell_q[g] <= cell_d[g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  // Request and result registers carry payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= req_type_i;
      value_q <= item_value_i;
      pos_q   <= position_i;
    end
    if (cmd_i.execute) begin
      res_status_q <= status_d;
      res_count_q  <= ENTRY_W'(count_d);
      res_valid_q  <= (count_d != '0);
      res_front_q  <= (count_d != '0) ? front_d : '0;
    end
  end

  assign status_o      = res_status_q;
  assign entry_count_o = res_count_q;
  assign front_value_o = res_front_q;
  assign front_valid_o = res_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit values with insert and delete at a position.
// ----------------------------------------------------------------------------
// Each item on the slave stream is one request: insert at the front, at the
// back or at a 1-based position, delete the front, or delete at a 1-based
// position. Every request gives exactly one result item on the master stream
// with the status, the entry count and the front entry. Each request is first
// captured and then applied, as the cells from the target position onward
// move by one place; a result that is not taken holds the update back, and
// no new request is captured while the update waits.
// The store holds up to CAPACITY entries; its contents need no clearing after
// reset since only entries below the count are ever read.
`default_nettype none

`include "positional_list_engine_defines.svh"

module positional_list_engine
  import ple_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata fields from bit 0: item_value[31:0], position[47:32]
  input  wire logic [47:0] s_axis_tdata,
  // tuser fields from bit 0: req_type[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata fields from bit 0: status[1:0], entry_count[7:2],
  // front_value[39:8], front_valid[40], zero fill[47:41]
  output logic [47:0]      m_axis_tdata
);

  ple_cmd_t           cmd;
  logic [1:0]         status;
  logic [ENTRY_W-1:0] entry_count;
  logic [DATA_W-1:0]  front_value;
  logic               front_valid;

  // The controller decides when a request is taken and when the list moves.
  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // The datapath holds the cells, the count and the result register.
  ple_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (s_axis_tuser),
    .item_value_i  (s_axis_tdata[31:0]),
    .position_i    (s_axis_tdata[47:32]),
    .status_o      (status),
    .entry_count_o (entry_count),
    .front_value_o (front_value),
    .front_valid_o (front_valid)
  );

  assign m_axis_tdata = {7'd0, front_valid, front_value, entry_count, status};

  // A shown result reports a valid front exactly when the list is not empty.
  `PLE_ASSERT_IMPLIES(a_front_valid, clk_i, rst_ni, m_axis_tvalid, front_valid == (entry_count != '0))
  // A full status is only given when the list is at capacity.
  `PLE_ASSERT_IMPLIES(a_full_count, clk_i, rst_ni, m_axis_tvalid && status == STAT_FULL, entry_count == ENTRY_W'(CAPACITY))
  // An empty status is only given when the list is empty.
  `PLE_ASSERT_IMPLIES(a_empty_count, clk_i, rst_ni, m_axis_tvalid && status == STAT_EMPTY, entry_count == '0)
  // After a request is taken, the update comes before the next request.
  `PLE_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, cmd.capture, !s_axis_tready)

endmodule

`default_nettype wire
